// ----- hdl/badq_pkg.sv -----
// Package: word types, opcodes, status codes and control types of the deque core.
`timescale 1ns / 1ps
`default_nettype none
package badq_pkg;

    localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [3:0] OP_POP_BACK   = 4'd2;
    localparam logic [3:0] OP_POP_FRONT  = 4'd3;
    localparam logic [3:0] OP_PEEK_FRONT = 4'd4;
    localparam logic [3:0] OP_PEEK_BACK  = 4'd5;
    localparam logic [3:0] OP_FIND       = 4'd6;
    localparam logic [3:0] OP_DELETE     = 4'd7;
    localparam logic [3:0] OP_CLEAR      = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] value_in;
        logic [5:0]  range_first;
        logic [5:0]  range_last;
    } badq_in_t;

    typedef struct packed {
        logic [31:0] value_out;
        logic        found;
        logic [5:0]  found_index;
        logic [6:0]  element_count;
        logic [1:0]  status;
    } badq_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FINISH
    } badq_state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic finish;
    } badq_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic hit;
        logic out_free;
    } badq_sts_t;

endpackage
`default_nettype wire

// ----- hdl/badq_ctrl.sv -----
// Controller: sequences accept, decode, memory walk and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module badq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire badq_pkg::badq_sts_t sts,
    output badq_pkg::badq_cmd_t      cmd
);

    badq_pkg::badq_state_t state_reg;
    badq_pkg::badq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= badq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            badq_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = badq_pkg::S_EXEC;
                end
            end
            badq_pkg::S_EXEC:
            begin
                state_next = badq_pkg::S_WALK;
            end
            badq_pkg::S_WALK:
            begin
                if (sts.walk_last || sts.hit)
                begin
                    state_next = badq_pkg::S_FINISH;
                end
            end
            badq_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = badq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = badq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            badq_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            badq_pkg::S_EXEC:
            begin
                cmd.setup = 1'b1;
            end
            badq_pkg::S_WALK:
            begin
                cmd.step = 1'b1;
            end
            badq_pkg::S_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/badq_datapath.sv -----
// Datapath: entry memory, occupancy, walk pointers and the result register.
`timescale 1ns / 1ps
`default_nettype none
module badq_datapath #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire badq_pkg::badq_in_t  item,
    input  wire badq_pkg::badq_cmd_t cmd,
    output badq_pkg::badq_sts_t      sts,
    input  wire logic                result_stall,
    output logic                     result_valid,
    output badq_pkg::badq_out_t      result
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int IW   = (AW > 6) ? AW : 6;
    localparam int OCW  = (CW > 7) ? CW : 7;

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [3:0]           op_reg,    op_next;
    logic [WORD_BITS-1:0] word_reg,  word_next;
    logic [5:0]           first_reg, first_next;
    logic [5:0]           last_reg,  last_next;
    logic [AW-1:0]        src_reg,   src_next;
    logic [AW-1:0]        dst_reg,   dst_next;
    logic [AW-1:0]        paddr_reg, paddr_next;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] val_reg,   val_next;
    logic                 fnd_reg,   fnd_next;
    logic [5:0]           fidx_reg,  fidx_next;
    logic [1:0]           st_reg,    st_next;
    badq_pkg::badq_out_t  result_reg, result_next;

    logic [CW-1:0]        occ_reg,   occ_next;
    logic [CW-1:0]        left_reg,  left_next;
    logic                 pend_reg,  pend_next;
    logic                 capt_reg,  capt_next;
    logic                 result_valid_reg, result_valid_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [AW-1:0]        raddr;

    logic [63:0]          vin_wide;
    logic [63:0]          vout_wide;
    logic [IW-1:0]        pidx_wide;
    logic [OCW-1:0]       occ_wide;
    logic [CMPW-1:0]      occ_cmp, first_cmp, last_cmp, del_cnt, del_left;
    logic [CW-1:0]        occ_m1;
    logic                 empty, full, bad_range;
    logic                 is_move, is_up, is_find, hit;

    assign vin_wide  = 64'(item.value_in);
    assign vout_wide = 64'(val_reg);
    assign pidx_wide = IW'(paddr_reg);
    assign occ_wide  = OCW'(occ_reg);

    assign occ_cmp   = CMPW'(occ_reg);
    assign first_cmp = CMPW'(first_reg);
    assign last_cmp  = CMPW'(last_reg);
    assign del_cnt   = last_cmp - first_cmp + CMPW'(1);
    assign del_left  = occ_cmp - last_cmp - CMPW'(1);
    assign occ_m1    = occ_reg - CW'(1);

    assign empty     = (occ_reg == '0);
    assign full      = (occ_reg == CW'(DEPTH));
    assign bad_range = (first_cmp > last_cmp) || (last_cmp >= occ_cmp);

    assign is_up   = (op_reg == badq_pkg::OP_PUSH_FRONT);
    assign is_find = (op_reg == badq_pkg::OP_FIND);
    assign is_move = is_up || (op_reg == badq_pkg::OP_POP_FRONT)
                     || (op_reg == badq_pkg::OP_DELETE);
    assign hit     = pend_reg && !capt_reg && is_find && (rdata_reg == word_reg);

    assign sts.walk_last = (left_reg == '0);
    assign sts.hit       = hit;
    assign sts.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        op_next           = op_reg;
        word_next         = word_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        src_next          = src_reg;
        dst_next          = dst_reg;
        paddr_next        = paddr_reg;
        val_next          = val_reg;
        fnd_next          = fnd_reg;
        fidx_next         = fidx_reg;
        st_next           = st_reg;
        occ_next          = occ_reg;
        left_next         = left_reg;
        pend_next         = pend_reg;
        capt_next         = capt_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        we                = 1'b0;
        waddr             = '0;
        wdata             = word_reg;
        re                = 1'b0;
        raddr             = '0;

        if (cmd.load)
        begin
            op_next    = item.opcode;
            word_next  = vin_wide[WORD_BITS-1:0];
            first_next = item.range_first;
            last_next  = item.range_last;
        end

        if (cmd.setup)
        begin
            val_next  = '0;
            fnd_next  = 1'b0;
            fidx_next = '0;
            st_next   = badq_pkg::ST_OK;
            pend_next = 1'b0;
            capt_next = 1'b0;
            left_next = '0;
            unique case (op_reg)
                badq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        st_next = badq_pkg::ST_FULL;
                    end
                    else
                    begin
                        we       = 1'b1;
                        waddr    = occ_reg[AW-1:0];
                        occ_next = occ_reg + CW'(1);
                    end
                end
                badq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        st_next = badq_pkg::ST_FULL;
                    end
                    else
                    begin
                        src_next  = occ_m1[AW-1:0];
                        dst_next  = occ_reg[AW-1:0];
                        left_next = occ_reg;
                        occ_next  = occ_reg + CW'(1);
                    end
                end
                badq_pkg::OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        st_next = badq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        re        = 1'b1;
                        raddr     = occ_m1[AW-1:0];
                        pend_next = 1'b1;
                        capt_next = 1'b1;
                        occ_next  = occ_m1;
                    end
                end
                badq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        st_next = badq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        re        = 1'b1;
                        raddr     = '0;
                        pend_next = 1'b1;
                        capt_next = 1'b1;
                        src_next  = AW'(1);
                        dst_next  = '0;
                        left_next = occ_m1;
                        occ_next  = occ_m1;
                    end
                end
                badq_pkg::OP_PEEK_FRONT:
                begin
                    if (empty)
                    begin
                        st_next = badq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        re        = 1'b1;
                        raddr     = '0;
                        pend_next = 1'b1;
                        capt_next = 1'b1;
                    end
                end
                badq_pkg::OP_PEEK_BACK:
                begin
                    if (empty)
                    begin
                        st_next = badq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        re        = 1'b1;
                        raddr     = occ_m1[AW-1:0];
                        pend_next = 1'b1;
                        capt_next = 1'b1;
                    end
                end
                badq_pkg::OP_FIND:
                begin
                    src_next  = '0;
                    left_next = occ_reg;
                end
                badq_pkg::OP_DELETE:
                begin
                    if (bad_range)
                    begin
                        st_next = badq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        src_next  = AW'(last_cmp + CMPW'(1));
                        dst_next  = AW'(first_cmp);
                        left_next = CW'(del_left);
                        occ_next  = CW'(occ_cmp - del_cnt);
                    end
                end
                badq_pkg::OP_CLEAR:
                begin
                    occ_next = '0;
                end
                default:
                begin
                    st_next = badq_pkg::ST_OK;
                end
            endcase
        end

        if (cmd.step)
        begin
            if (left_reg != '0)
            begin
                re         = 1'b1;
                raddr      = src_reg;
                paddr_next = src_reg;
                src_next   = is_up ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                left_next  = left_reg - CW'(1);
                pend_next  = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end

            if (pend_reg)
            begin
                if (capt_reg)
                begin
                    val_next  = rdata_reg;
                    capt_next = 1'b0;
                end
                else if (is_move)
                begin
                    we       = 1'b1;
                    waddr    = dst_reg;
                    wdata    = rdata_reg;
                    dst_next = is_up ? (dst_reg - AW'(1)) : (dst_reg + AW'(1));
                end
                else if (hit)
                begin
                    fnd_next  = 1'b1;
                    fidx_next = pidx_wide[5:0];
                end
            end
        end

        if (cmd.finish)
        begin
            // front insert lands at index 0 once the shift has finished
            if (is_up && (st_reg == badq_pkg::ST_OK))
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = word_reg;
            end
            result_next.value_out     = vout_wide[31:0];
            result_next.found         = fnd_reg;
            result_next.found_index   = fidx_reg;
            result_next.element_count = occ_wide[6:0];
            result_next.status        = st_reg;
            result_valid_next         = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        word_reg   <= word_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        paddr_reg  <= paddr_next;
        val_reg    <= val_next;
        fnd_reg    <= fnd_next;
        fidx_reg   <= fidx_next;
        st_reg     <= st_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg          <= '0;
            left_reg         <= '0;
            pend_reg         <= 1'b0;
            capt_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg          <= occ_next;
            left_reg         <= left_next;
            pend_reg         <= pend_next;
            capt_reg         <= capt_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/bounded_array_deque_with_search_core.sv -----
// Top level: bounded array deque with linear search.
//
// Input channel item_valid / item_stall / item carries one word: opcode,
// value, and an inclusive index range for deletion. Output channel
// result_valid / result_stall / result returns one word per input word:
// popped or peeked value, find hit and index, element count and status.
//
// One word is in flight at a time. The result waits on a walk of n memory
// entries: the held count for find (less on an early hit) and front insert,
// count - 1 for front pop, the tail length for range delete, and zero
// otherwise. The walk is bound by the single read and single write port of
// the entry memory, one entry per cycle. The next word is taken in the cycle
// after the result is loaded.
//
// Reset empties the list at once; entry contents are left as they are.
// A stalled result holds in the output register; a new word may be taken
// meanwhile, but its result waits until the held one has been taken.
`timescale 1ns / 1ps
`default_nettype none
module bounded_array_deque_with_search_core #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire badq_pkg::badq_in_t item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output badq_pkg::badq_out_t     result
);

    badq_pkg::badq_cmd_t cmd;
    badq_pkg::badq_sts_t sts;

    badq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    badq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire
